// ===== hdl/dpb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the depth pixel back-projection block.
package dpb_pkg;

    // Configuration port geometry and register indexes.
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 16;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_FOCAL_X     = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_FOCAL_Y     = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_CENTER_X    = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_CENTER_Y    = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DEPTH_SCALE = 3'd4;

    // Register values after reset.
    localparam logic [15:0] C_RST_FOCAL_X     = 16'd9280;
    localparam logic [15:0] C_RST_FOCAL_Y     = 16'd9280;
    localparam logic [15:0] C_RST_CENTER_X    = 16'd5104;
    localparam logic [15:0] C_RST_CENTER_Y    = 16'd3792;
    localparam logic [15:0] C_RST_DEPTH_SCALE = 16'd1000;

    localparam logic [31:0] C_RST_DEN_X = 32'(C_RST_FOCAL_X) * 32'(C_RST_DEPTH_SCALE);
    localparam logic [31:0] C_RST_DEN_Y = 32'(C_RST_FOCAL_Y) * 32'(C_RST_DEPTH_SCALE);
    localparam logic [31:0] C_RST_DEN_Z = 32'(C_RST_DEPTH_SCALE);

    // Frame limits; pixels beyond them are clamped to the last row or column.
    localparam int C_MAX_WIDTH  = 1024;
    localparam int C_MAX_HEIGHT = 1024;

    // Divider geometry: one quotient bit per pipeline stage.
    localparam int C_DIV_STEPS = 32;

    // Lanes of the divider array.
    localparam int C_LANES  = 3;
    localparam int C_LANE_X = 0;
    localparam int C_LANE_Y = 1;
    localparam int C_LANE_Z = 2;

    // Saturation limits of the outputs.
    localparam logic [31:0] C_S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_S32_MIN = 32'h8000_0000;
    localparam logic [31:0] C_U32_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_color;

    // Sideband that travels with an item through the divider.
    typedef struct packed {
        logic   neg_x;
        logic   neg_y;
        t_color color;
    } t_side;

    // Dividend of 48 bits, split into the part that seeds the remainder and the rest.
    typedef struct packed {
        logic [15:0] hi;
        logic [31:0] lo;
    } t_dividend;

    // State of one divider lane in one stage.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] nq;
        logic        ovf;
    } t_div_lane;

    // Finished quotient of one lane.
    typedef struct packed {
        logic [31:0] quo;
        logic [31:0] rem;
        logic        ovf;
    } t_div_res;

    typedef struct packed {
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [31:0] z_pos;
        t_color      color;
    } t_point;

    // A divisor register that holds zero acts as one.
    function automatic logic [15:0] nonzero16(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div_lane div_step(input t_div_lane cur, input logic [31:0] den);
        logic [32:0] trial;
        logic [32:0] diff;
        t_div_lane   nxt;
        trial   = {cur.rem, cur.nq[31]};
        diff    = trial - {1'b0, den};
        nxt.ovf = cur.ovf;
        nxt.rem = diff[32] ? trial[31:0] : diff[31:0];
        nxt.nq  = {cur.nq[30:0], ~diff[32]};
        return nxt;
    endfunction

    // Signed saturation of a rounded magnitude with its sign.
    function automatic logic [31:0] sat_signed(input logic [32:0] mag, input logic ovf,
                                               input logic neg);
        logic [31:0] res;
        if (ovf) begin
            res = neg ? C_S32_MIN : C_S32_MAX;
        end else if (!neg) begin
            res = (mag > {1'b0, C_S32_MAX}) ? C_S32_MAX : mag[31:0];
        end else begin
            res = (mag >= {1'b0, C_S32_MIN}) ? C_S32_MIN : (32'd0 - mag[31:0]);
        end
        return res;
    endfunction

    // Unsigned saturation of a rounded value.
    function automatic logic [31:0] sat_unsigned(input logic [32:0] mag, input logic ovf);
        return (ovf || mag[32]) ? C_U32_MAX : mag[31:0];
    endfunction

endpackage

// ===== hdl/depth_pixel_backprojection_top.sv =====
// Top level of the depth pixel back-projection block: configuration registers and pipeline.
//
//   Channel   Direction  Handshake                   Payload
//   pixel     in         i_valid / o_stall           row, column, raw depth, BGR color
//   point     out        o_valid / i_stall           X, Y, Z in Q16.16, BGR color
//   config    in         i_cfg_valid / o_cfg_ready   register index, 16-bit data
//
// One item is accepted per cycle while o_stall is low.
// The core of the pipeline is the 32-stage restoring divider, one quotient bit per stage,
// with three lanes (X, Y, Z) side by side.
// A two-entry output queue lets the pipeline run on while the sink stalls; input
// stalls only when both queue entries are occupied.
// Reset is synchronous; it clears valid bits and queue pointers and presets the registers.
module depth_pixel_backprojection_top #(
    parameter int P_MAX_WIDTH  = dpb_pkg::C_MAX_WIDTH,
    parameter int P_MAX_HEIGHT = dpb_pkg::C_MAX_HEIGHT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [9:0]                           i_pixel_row,
    input  logic [9:0]                           i_pixel_col,
    input  logic [15:0]                          i_depth_raw,
    input  logic [7:0]                           i_blue_in,
    input  logic [7:0]                           i_green_in,
    input  logic [7:0]                           i_red_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [31:0]                   o_x_pos,
    output logic signed [31:0]                   o_y_pos,
    output logic [31:0]                          o_z_pos,
    output logic [7:0]                           o_blue_out,
    output logic [7:0]                           o_green_out,
    output logic [7:0]                           o_red_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dpb_pkg::C_CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dpb_pkg::C_CFG_DATA_W-1:0]     i_cfg_data
);
    import dpb_pkg::*;

    // Configuration registers.
    logic [15:0] r_focal_x;
    logic [15:0] r_focal_y;
    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [15:0] r_depth_scale;

    // Divisors for each lane, recomputed from the registers every cycle.
    logic [C_LANES-1:0][31:0] r_den;
    logic [C_LANES-1:0][31:0] n_den;

    // Pipeline interconnect.
    logic                     w_adv;
    logic                     w_front_valid;
    t_dividend [C_LANES-1:0]  w_front_num;
    t_side                    w_front_side;
    logic                     w_div_valid;
    t_div_res [C_LANES-1:0]   w_div_res;
    t_side                    w_div_side;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !w_adv;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x     <= C_RST_FOCAL_X;
            r_focal_y     <= C_RST_FOCAL_Y;
            r_center_x    <= C_RST_CENTER_X;
            r_center_y    <= C_RST_CENTER_Y;
            r_depth_scale <= C_RST_DEPTH_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                C_REG_FOCAL_X:     r_focal_x     <= i_cfg_data;
                C_REG_FOCAL_Y:     r_focal_y     <= i_cfg_data;
                C_REG_CENTER_X:    r_center_x    <= i_cfg_data;
                C_REG_CENTER_Y:    r_center_y    <= i_cfg_data;
                C_REG_DEPTH_SCALE: r_depth_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Divisor of X and Y is depth scale times focal length; Z divides by depth scale alone.
    always_comb begin
        n_den[C_LANE_X] = {16'd0, nonzero16(r_focal_x)} * {16'd0, nonzero16(r_depth_scale)};
        n_den[C_LANE_Y] = {16'd0, nonzero16(r_focal_y)} * {16'd0, nonzero16(r_depth_scale)};
        n_den[C_LANE_Z] = {16'd0, nonzero16(r_depth_scale)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den[C_LANE_X] <= C_RST_DEN_X;
            r_den[C_LANE_Y] <= C_RST_DEN_Y;
            r_den[C_LANE_Z] <= C_RST_DEN_Z;
        end else begin
            r_den <= n_den;
        end
    end

    dpb_front #(
        .P_MAX_WIDTH  (P_MAX_WIDTH),
        .P_MAX_HEIGHT (P_MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (i_valid),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_depth_raw (i_depth_raw),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .o_valid     (w_front_valid),
        .o_num       (w_front_num),
        .o_side      (w_front_side)
    );

    dpb_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_front_valid),
        .i_num   (w_front_num),
        .i_den   (r_den),
        .i_side  (w_front_side),
        .o_valid (w_div_valid),
        .o_res   (w_div_res),
        .o_side  (w_div_side)
    );

    dpb_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_div_valid),
        .i_res       (w_div_res),
        .i_den       (r_den),
        .i_side      (w_div_side),
        .i_stall     (i_stall),
        .o_adv       (w_adv),
        .o_valid     (o_valid),
        .o_x_pos     (o_x_pos),
        .o_y_pos     (o_y_pos),
        .o_z_pos     (o_z_pos),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out)
    );

`ifndef SYNTHESIS
    // A zero register must never reach the divider as a zero divisor.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_den[C_LANE_X] != '0) && (r_den[C_LANE_Y] != '0) && (r_den[C_LANE_Z] != '0))
        else $error("divisor register holds zero");

    // Input is held back only when finished items are waiting at the output.
    a_stall_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output queue");

    // Delivering an item always frees room for the pipeline in the next cycle.
    a_pop_frees_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_stall)
        else $error("queue still full after an item was taken");
`endif

endmodule

// ===== hdl/dpb_front.sv =====
// Front pipeline: clamps the pixel, centers it and forms the numerators of the three divisions.
module dpb_front #(
    parameter int P_MAX_WIDTH  = dpb_pkg::C_MAX_WIDTH,
    parameter int P_MAX_HEIGHT = dpb_pkg::C_MAX_HEIGHT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic [9:0]                           i_pixel_row,
    input  logic [9:0]                           i_pixel_col,
    input  logic [15:0]                          i_depth_raw,
    input  logic [7:0]                           i_blue_in,
    input  logic [7:0]                           i_green_in,
    input  logic [7:0]                           i_red_in,
    input  logic [15:0]                          i_center_x,
    input  logic [15:0]                          i_center_y,
    output logic                                 o_valid,
    output dpb_pkg::t_dividend [dpb_pkg::C_LANES-1:0] o_num,
    output dpb_pkg::t_side                       o_side
);
    import dpb_pkg::*;

    // Stage A: the accepted item.
    logic        r_a_valid;
    logic [9:0]  r_a_row;
    logic [9:0]  r_a_col;
    logic [15:0] r_a_depth;
    t_color      r_a_color;

    // Stage B: offsets from the principal point in 1/16 pixel, two's complement.
    logic        r_b_valid;
    logic [17:0] r_b_dx;
    logic [17:0] r_b_dy;
    logic [15:0] r_b_depth;
    t_color      r_b_color;
    logic [17:0] n_b_dx;
    logic [17:0] n_b_dy;
    logic [9:0]  n_b_row;
    logic [9:0]  n_b_col;

    // Stage C: sign and magnitude of the offsets.
    logic        r_c_valid;
    logic        r_c_neg_x;
    logic        r_c_neg_y;
    logic [15:0] r_c_mag_x;
    logic [15:0] r_c_mag_y;
    logic [15:0] r_c_depth;
    t_color      r_c_color;
    logic [15:0] n_c_mag_x;
    logic [15:0] n_c_mag_y;

    // Stage D: magnitude times raw depth.
    logic        r_d_valid;
    logic [31:0] r_d_prod_x;
    logic [31:0] r_d_prod_y;
    logic [15:0] r_d_depth;
    t_side       r_d_side;
    logic [31:0] n_d_prod_x;
    logic [31:0] n_d_prod_y;

    // Valid bits move with the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Clamp to the frame and subtract the principal point.
    always_comb begin
        n_b_col = (32'(r_a_col) >= P_MAX_WIDTH)  ? 10'(P_MAX_WIDTH - 1)  : r_a_col;
        n_b_row = (32'(r_a_row) >= P_MAX_HEIGHT) ? 10'(P_MAX_HEIGHT - 1) : r_a_row;
        n_b_dx  = {4'd0, n_b_col, 4'd0} - {2'd0, i_center_x};
        n_b_dy  = {4'd0, n_b_row, 4'd0} - {2'd0, i_center_y};
    end

    // Take the offsets apart into sign and magnitude.
    always_comb begin
        n_c_mag_x = r_b_dx[17] ? 16'(18'd0 - r_b_dx) : r_b_dx[15:0];
        n_c_mag_y = r_b_dy[17] ? 16'(18'd0 - r_b_dy) : r_b_dy[15:0];
    end

    // Scale the magnitudes by the raw depth.
    always_comb begin
        n_d_prod_x = {16'd0, r_c_mag_x} * {16'd0, r_c_depth};
        n_d_prod_y = {16'd0, r_c_mag_y} * {16'd0, r_c_depth};
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_row         <= i_pixel_row;
            r_a_col         <= i_pixel_col;
            r_a_depth       <= i_depth_raw;
            r_a_color       <= '{blue: i_blue_in, green: i_green_in, red: i_red_in};
            r_b_dx          <= n_b_dx;
            r_b_dy          <= n_b_dy;
            r_b_depth       <= r_a_depth;
            r_b_color       <= r_a_color;
            r_c_neg_x       <= r_b_dx[17];
            r_c_neg_y       <= r_b_dy[17];
            r_c_mag_x       <= n_c_mag_x;
            r_c_mag_y       <= n_c_mag_y;
            r_c_depth       <= r_b_depth;
            r_c_color       <= r_b_color;
            r_d_prod_x      <= n_d_prod_x;
            r_d_prod_y      <= n_d_prod_y;
            r_d_depth       <= r_c_depth;
            r_d_side.neg_x  <= r_c_neg_x;
            r_d_side.neg_y  <= r_c_neg_y;
            r_d_side.color  <= r_c_color;
        end
    end

    // Dividends are the products and the depth, each scaled by 2^16 for Q16.16.
    always_comb begin
        o_num[C_LANE_X].hi = r_d_prod_x[31:16];
        o_num[C_LANE_X].lo = {r_d_prod_x[15:0], 16'd0};
        o_num[C_LANE_Y].hi = r_d_prod_y[31:16];
        o_num[C_LANE_Y].lo = {r_d_prod_y[15:0], 16'd0};
        o_num[C_LANE_Z].hi = 16'd0;
        o_num[C_LANE_Z].lo = {r_d_depth, 16'd0};
    end

    assign o_valid = r_d_valid;
    assign o_side  = r_d_side;

endmodule

// ===== hdl/dpb_divider.sv =====
// Pipelined restoring divider: three lanes, one quotient bit per stage, with overflow detection.
module dpb_divider (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_adv,
    input  logic                                       i_valid,
    input  dpb_pkg::t_dividend [dpb_pkg::C_LANES-1:0]  i_num,
    input  logic [dpb_pkg::C_LANES-1:0][31:0]          i_den,
    input  dpb_pkg::t_side                             i_side,
    output logic                                       o_valid,
    output dpb_pkg::t_div_res [dpb_pkg::C_LANES-1:0]   o_res,
    output dpb_pkg::t_side                             o_side
);
    import dpb_pkg::*;

    // Stage 0 holds the seeded remainder; stages 1..C_DIV_STEPS each add one quotient bit.
    logic [C_DIV_STEPS:0]     r_valid;
    t_div_lane [C_LANES-1:0]  r_lane [0:C_DIV_STEPS];
    t_div_lane [C_LANES-1:0]  n_lane [0:C_DIV_STEPS];
    t_side                    r_side [0:C_DIV_STEPS];

    // Seed and step logic for every stage and lane.
    always_comb begin
        for (int l = 0; l < C_LANES; l++) begin
            n_lane[0][l].rem = {16'd0, i_num[l].hi};
            n_lane[0][l].nq  = i_num[l].lo;
            n_lane[0][l].ovf = ({16'd0, i_num[l].hi} >= i_den[l]);
        end
        for (int k = 1; k <= C_DIV_STEPS; k++) begin
            for (int l = 0; l < C_LANES; l++) begin
                n_lane[k][l] = div_step(r_lane[k-1][l], i_den[l]);
            end
        end
    end

    // Valid bits shift along with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[C_DIV_STEPS-1:0], i_valid};
        end
    end

    // Lane state and sideband registers.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int k = 0; k <= C_DIV_STEPS; k++) begin
                r_lane[k] <= n_lane[k];
            end
            for (int k = 1; k <= C_DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // After the last step the low word holds the quotient.
    always_comb begin
        for (int l = 0; l < C_LANES; l++) begin
            o_res[l].quo = r_lane[C_DIV_STEPS][l].nq;
            o_res[l].rem = r_lane[C_DIV_STEPS][l].rem;
            o_res[l].ovf = r_lane[C_DIV_STEPS][l].ovf;
        end
    end

    assign o_valid = r_valid[C_DIV_STEPS];
    assign o_side  = r_side[C_DIV_STEPS];

endmodule

// ===== hdl/dpb_round.sv =====
// Rounding, saturation and the two-entry output queue that decouples the pipeline from the sink.
module dpb_round (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  dpb_pkg::t_div_res [dpb_pkg::C_LANES-1:0]  i_res,
    input  logic [dpb_pkg::C_LANES-1:0][31:0]         i_den,
    input  dpb_pkg::t_side                            i_side,
    input  logic                                      i_stall,
    output logic                                      o_adv,
    output logic                                      o_valid,
    output logic signed [31:0]                        o_x_pos,
    output logic signed [31:0]                        o_y_pos,
    output logic [31:0]                               o_z_pos,
    output logic [7:0]                                o_blue_out,
    output logic [7:0]                                o_green_out,
    output logic [7:0]                                o_red_out
);
    import dpb_pkg::*;

    // Rounding stage: quotient plus one when the remainder is at least half the divisor.
    logic                    r_r1_valid;
    logic [C_LANES-1:0][32:0] r_r1_q;
    logic [C_LANES-1:0]      r_r1_ovf;
    t_side                   r_r1_side;
    logic [C_LANES-1:0][32:0] n_r1_q;

    // Output queue.
    t_point      r_q [0:1];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    t_point      n_point;
    logic        w_push;
    logic        w_pop;

    // The pipeline moves whenever the queue has a free entry.
    assign o_adv  = (r_count != 2'd2);
    assign w_push = o_adv && r_r1_valid;
    assign w_pop  = (r_count != 2'd0) && !i_stall;

    always_comb begin
        for (int l = 0; l < C_LANES; l++) begin
            n_r1_q[l] = {1'b0, i_res[l].quo}
                      + 33'({i_res[l].rem, 1'b0} >= {1'b0, i_den[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_valid <= 1'b0;
        end else if (o_adv) begin
            r_r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_r1_q    <= n_r1_q;
            r_r1_side <= i_side;
            for (int l = 0; l < C_LANES; l++) begin
                r_r1_ovf[l] <= i_res[l].ovf;
            end
        end
    end

    // Saturate into the output formats.
    always_comb begin
        n_point.x_pos = sat_signed(r_r1_q[C_LANE_X], r_r1_ovf[C_LANE_X], r_r1_side.neg_x);
        n_point.y_pos = sat_signed(r_r1_q[C_LANE_Y], r_r1_ovf[C_LANE_Y], r_r1_side.neg_y);
        n_point.z_pos = sat_unsigned(r_r1_q[C_LANE_Z], r_r1_ovf[C_LANE_Z]);
        n_point.color = r_r1_side.color;
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= n_point;
        end
    end

    assign o_valid     = (r_count != 2'd0);
    assign o_x_pos     = r_q[r_rd_ptr].x_pos;
    assign o_y_pos     = r_q[r_rd_ptr].y_pos;
    assign o_z_pos     = r_q[r_rd_ptr].z_pos;
    assign o_blue_out  = r_q[r_rd_ptr].color.blue;
    assign o_green_out = r_q[r_rd_ptr].color.green;
    assign o_red_out   = r_q[r_rd_ptr].color.red;

endmodule

// ===== verif/tb_depth_pixel_backprojection_top.sv =====
// Self-checking testbench for the depth pixel back-projection top level.
module tb_depth_pixel_backprojection_top;
    import dpb_pkg::*;

    // Cycles to let the pipeline settle after the last point, and the stall watchdog.
    localparam int C_SETTLE_CYCLES = 64;
    localparam int C_HOLD_CYCLES   = 300;
    localparam int C_WATCHDOG_MAX  = 5000;
    localparam int C_PHASES        = 8;
    localparam int C_PHASE_ITEMS   = 185;

    typedef struct {
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] depth;
        t_color      color;
    } t_pixel_item;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [9:0]  i_pixel_row  = '0;
    logic [9:0]  i_pixel_col  = '0;
    logic [15:0] i_depth_raw  = '0;
    logic [7:0]  i_blue_in    = '0;
    logic [7:0]  i_green_in   = '0;
    logic [7:0]  i_red_in     = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic signed [31:0] o_x_pos;
    logic signed [31:0] o_y_pos;
    logic [31:0] o_z_pos;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_red_out;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [C_CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [C_CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Pixels waiting to be offered, and points predicted for accepted pixels.
    t_pixel_item pixel_q[$];
    t_point      point_q[$];
    t_pixel_item offered_px;

    // Shadow copy of the intrinsics registers.
    logic [15:0] intrinsics [0:4];

    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int pixels_sent   = 0;
    int points_seen   = 0;
    int reg_writes    = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    depth_pixel_backprojection_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_depth_raw (i_depth_raw),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_x_pos     (o_x_pos),
        .o_y_pos     (o_y_pos),
        .o_z_pos     (o_z_pos),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One axis of the projection: offset from the principal point times depth over the
    // combined divisor, rounded half away from zero and saturated to signed Q16.16.
    function automatic logic [31:0] project_axis(input logic [9:0] pos, input int limit,
                                                 input logic [15:0] center,
                                                 input logic [63:0] den,
                                                 input logic [15:0] depth);
        int              p;
        longint          offset;
        longint          num;
        longint unsigned mag;
        longint unsigned q;
        longint          res;
        p      = (int'(pos) >= limit) ? limit - 1 : int'(pos);
        offset = 16 * longint'(p) - longint'({48'd0, center});
        num    = offset * longint'({48'd0, depth}) * 64'sd65536;
        mag    = (num < 0) ? unsigned'(-num) : unsigned'(num);
        q      = (2 * mag + den) / (2 * den);
        res    = (num < 0) ? -signed'(q) : signed'(q);
        if (res > 64'sd2147483647) begin
            res = 64'sd2147483647;
        end
        if (res < -64'sd2147483648) begin
            res = -64'sd2147483648;
        end
        return res[31:0];
    endfunction

    // Expected point for one pixel under the current intrinsics.
    function automatic t_point backproject(input t_pixel_item px);
        t_point      pt;
        logic [63:0] scale;
        logic [63:0] fx;
        logic [63:0] fy;
        logic [63:0] znum;
        logic [63:0] zq;
        // A divisor register holding zero behaves as one.
        scale = (intrinsics[C_REG_DEPTH_SCALE] == 16'd0) ? 64'd1
                                                          : {48'd0, intrinsics[C_REG_DEPTH_SCALE]};
        fx    = (intrinsics[C_REG_FOCAL_X] == 16'd0) ? 64'd1 : {48'd0, intrinsics[C_REG_FOCAL_X]};
        fy    = (intrinsics[C_REG_FOCAL_Y] == 16'd0) ? 64'd1 : {48'd0, intrinsics[C_REG_FOCAL_Y]};
        pt.x_pos = project_axis(px.col, C_MAX_WIDTH, intrinsics[C_REG_CENTER_X], scale * fx,
                                px.depth);
        pt.y_pos = project_axis(px.row, C_MAX_HEIGHT, intrinsics[C_REG_CENTER_Y], scale * fy,
                                px.depth);
        znum     = {32'd0, px.depth, 16'd0};
        zq       = (2 * znum + scale) / (2 * scale);
        pt.z_pos = (zq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zq[31:0];
        pt.color = px.color;
        return pt;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
            mismatches++;
        end
    endtask

    // Pixel source: offers the next queued item unless it decides to idle this cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                point_q = {point_q, backproject(offered_px)};
                pixels_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_px = pixel_q.pop_front();
                    i_pixel_row <= offered_px.row;
                    i_pixel_col <= offered_px.col;
                    i_depth_raw <= offered_px.depth;
                    i_blue_in   <= offered_px.color.blue;
                    i_green_in  <= offered_px.color.green;
                    i_red_in    <= offered_px.color.red;
                    i_valid     <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Point sink: checks each accepted point against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                points_seen++;
                if (point_q.size() == 0) begin
                    $error("point arrived with no pixel pending");
                    mismatches++;
                end else begin
                    t_point want;
                    want = point_q.pop_front();
                    check_field("x_pos", want.x_pos, o_x_pos);
                    check_field("y_pos", want.y_pos, o_y_pos);
                    check_field("z_pos", want.z_pos, o_z_pos);
                    check_field("blue_out", 32'(want.color.blue), 32'(o_blue_out));
                    check_field("green_out", 32'(want.color.green), 32'(o_green_out));
                    check_field("red_out", 32'(want.color.red), 32'(o_red_out));
                end
            end
            // A long hold-off lets the pipeline fill up and back-pressure the source.
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = C_HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < snk_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which no handshake completes.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= C_WATCHDOG_MAX) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_pixel(input logic [9:0] row, input logic [9:0] col,
                              input logic [15:0] depth, input logic [7:0] blue,
                              input logic [7:0] green, input logic [7:0] red);
        t_pixel_item px;
        px.row         = row;
        px.col         = col;
        px.depth       = depth;
        px.color.blue  = blue;
        px.color.green = green;
        px.color.red   = red;
        pixel_q = {pixel_q, px};
    endtask

    // Random pixel with corners, zero and full-scale depth weighted up.
    task automatic push_random_pixel();
        logic [9:0]  row;
        logic [9:0]  col;
        logic [15:0] depth;
        case ($urandom_range(9))
            0:       row = 10'd0;
            1:       row = 10'd1023;
            default: row = 10'($urandom_range(1023));
        endcase
        case ($urandom_range(9))
            0:       col = 10'd0;
            1:       col = 10'd1023;
            default: col = 10'($urandom_range(1023));
        endcase
        case ($urandom_range(9))
            0:       depth = 16'd0;
            1:       depth = 16'hFFFF;
            2, 3, 4: depth = 16'($urandom_range(4095, 1));
            default: depth = 16'($urandom());
        endcase
        push_pixel(row, col, depth, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        // Indexes past the register list are dropped by the block.
        if (idx <= C_REG_DEPTH_SCALE) begin
            intrinsics[idx] = val;
        end
    endtask

    task automatic set_intrinsics(input logic [15:0] fx, input logic [15:0] fy,
                                  input logic [15:0] cx, input logic [15:0] cy,
                                  input logic [15:0] scale);
        write_reg(C_REG_FOCAL_X, fx);
        write_reg(C_REG_FOCAL_Y, fy);
        write_reg(C_REG_CENTER_X, cx);
        write_reg(C_REG_CENTER_Y, cy);
        write_reg(C_REG_DEPTH_SCALE, scale);
    endtask

    // Waits until every queued pixel has produced its point, then lets the pipe settle.
    task automatic wait_drained();
        do @(negedge i_clk); while (pixel_q.size() != 0 || i_valid || point_q.size() != 0);
        repeat (C_SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Test sequence: reset, directed pixels, writes to unused register indexes, then random phases.
    initial begin
        intrinsics[C_REG_FOCAL_X]     = C_RST_FOCAL_X;
        intrinsics[C_REG_FOCAL_Y]     = C_RST_FOCAL_Y;
        intrinsics[C_REG_CENTER_X]    = C_RST_CENTER_X;
        intrinsics[C_REG_CENTER_Y]    = C_RST_CENTER_Y;
        intrinsics[C_REG_DEPTH_SCALE] = C_RST_DEPTH_SCALE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pixels under the reset intrinsics.
        src_idle_pct = 32;
        snk_idle_pct = 48;
        push_pixel(10'd0, 10'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        push_pixel(10'd1023, 10'd1023, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(10'd237, 10'd319, 16'd1000, 8'hAA, 8'h55, 8'hAA);
        push_pixel(10'd0, 10'd1023, 16'hFFFF, 8'h55, 8'hAA, 8'h55);
        push_pixel(10'd1023, 10'd0, 16'd1, 8'h01, 8'h80, 8'hFE);
        push_pixel(10'd512, 10'd512, 16'd32768, 8'h7F, 8'h01, 8'h80);
        push_pixel(10'd237, 10'd319, 16'hFFFF, 8'h12, 8'h34, 8'h56);
        push_pixel(10'd1023, 10'd1023, 16'd0, 8'hFF, 8'h00, 8'hFF);
        push_pixel(10'h2AA, 10'h155, 16'hAAAA, 8'hC3, 8'h3C, 8'h99);
        push_pixel(10'h155, 10'h2AA, 16'h5555, 8'h3C, 8'hC3, 8'h66);
        wait_drained();

        // Writes to indexes past the register list must leave the intrinsics alone.
        for (int idx = C_REG_DEPTH_SCALE + 1; idx < (1 << C_CFG_IDX_W); idx++) begin
            write_reg(idx[C_CFG_IDX_W-1:0], 16'($urandom()));
        end

        for (int p = 0; p < C_PHASES; p++) begin
            if (p < 3) begin
                src_idle_pct = 32;
                snk_idle_pct = 48;
            end else if (p < 6) begin
                src_idle_pct = 48;
                snk_idle_pct = 32;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case (p)
                0: ;
                1: begin
                    // Divisor of exactly 2^17 with odd offsets: each odd depth rounds on a tie.
                    set_intrinsics(16'd4, 16'd4, 16'd5105, 16'd3791, 16'd32768);
                    push_pixel(10'd0, 10'd0, 16'd1, 8'h00, 8'hFF, 8'h00);
                    push_pixel(10'd1023, 10'd1023, 16'd1, 8'hFF, 8'h00, 8'hFF);
                    push_pixel(10'd319, 10'd237, 16'd3, 8'h11, 8'h22, 8'h33);
                    push_pixel(10'd320, 10'd236, 16'hFFFF, 8'h44, 8'h55, 8'h66);
                end
                // Zero divisors act as one, so most coordinates saturate.
                2: set_intrinsics(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
                3: set_intrinsics(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: begin
                    if ($urandom_range(1) == 0) begin
                        set_intrinsics(16'($urandom_range(20000, 2000)),
                                       16'($urandom_range(20000, 2000)),
                                       16'($urandom_range(16368)), 16'($urandom_range(16368)),
                                       16'($urandom_range(10000, 1)));
                    end else begin
                        set_intrinsics(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                       16'($urandom()), 16'($urandom()));
                    end
                end
            endcase
            @(negedge i_clk);
            if (p >= 6) begin
                hold_req = 1'b1;
            end
            repeat (C_PHASE_ITEMS) push_random_pixel();
            wait_drained();
        end

        $display("Covered %0d pixels and %0d points over %0d register writes,", pixels_sent,
                 points_seen, reg_writes);
        $display("with zero divisors, extreme intrinsics, rounding ties and long stalls.");
        if (mismatches == 0 && point_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dpb_pkg.sv
hdl/dpb_front.sv
hdl/dpb_divider.sv
hdl/dpb_round.sv
hdl/depth_pixel_backprojection_top.sv
verif/tb_depth_pixel_backprojection_top.sv
